@@ hw/rtl/bam_pkg.sv @@
`default_nettype none
package bam_pkg;

  // Request opcodes on the input channel.
  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_SWEEP  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // Event codes; the code is also the bit index into event_enable.
  typedef enum logic [2:0] {
    EV_CONNECTED    = 3'd0,
    EV_DISCONNECTED = 3'd1,
    EV_FULL         = 3'd2,
    EV_LOW          = 3'd3,
    EV_CRITICAL     = 3'd4
  } event_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_LOW_THR  = 2'd0,
    CFG_CRIT_THR = 2'd1,
    CFG_COOLDOWN = 2'd2,
    CFG_EV_EN    = 2'd3
  } cfg_idx_e;

  // Charge state codes.
  localparam logic [1:0] CHG_DISCHARGING = 2'd0;
  localparam logic [1:0] CHG_CHARGING    = 2'd1;
  localparam logic [1:0] CHG_FULL        = 2'd2;
  localparam logic [1:0] CHG_UNKNOWN     = 2'd3;

  // Rate-limited alert kinds (index into the per-slot cooldown records).
  localparam logic [1:0] KIND_FULL = 2'd0;
  localparam logic [1:0] KIND_LOW  = 2'd1;
  localparam logic [1:0] KIND_CRIT = 2'd2;

  localparam int MARGIN  = 5;
  localparam int PCT_MAX = 100;
  localparam int CD_W    = 17;  // cooldown in seconds, up to 2047 * 60

  localparam logic [6:0]  LOW_THR_RST  = 7'd20;
  localparam logic [6:0]  CRIT_THR_RST = 7'd5;
  localparam logic [10:0] COOLDOWN_RST = 11'd30;
  localparam logic [4:0]  EV_EN_RST    = 5'd31;

  typedef struct packed {
    logic [1:0]        op;
    logic [3:0]        slot;
    logic signed [7:0] percent;
    logic [1:0]        charge;
    logic [31:0]       now_seconds;
  } item_t;

  typedef struct packed {
    logic [2:0]        event_res;
    logic [3:0]        event_slot;
    logic signed [7:0] event_percent;
    logic [1:0]        event_charge;
    logic              last;
  } event_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [10:0] value;
  } cfg_write_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT_CONN,
    ST_EMIT_RL,
    ST_SCAN,
    ST_SWEEP_EMIT
  } ctl_state_e;

  typedef struct packed {
    logic take;        // accept the input request
    logic eval;        // evaluate a report against slot state
    logic load_conn;   // load connected event into output register
    logic load_rl;     // load rate-limited event into output register
    logic sweep_read;  // read slot record at the sweep index
    logic load_disc;   // load disconnect event for the sweep index
    logic scan_next;   // advance the sweep index
  } ctl_cmd_t;

  typedef struct packed {
    logic in_report;
    logic in_sweep;
    logic out_busy;
    logic ev_conn;
    logic ev_rl;
    logic dm_empty;
    logic dm_bit;
  } ctl_status_t;

endpackage
`default_nettype wire

@@ hw/rtl/bam_stream_if.sv @@
`default_nettype none
interface bam_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/battery_alert_monitor.sv @@
// Battery alert monitor: per-slot battery tracking with alert events.
// in_i  (sink, bam_pkg::item_t): one request per valid/ready handshake; op selects a
//       device report, the end of a snapshot sweep, or a baseline/cooldown clear.
// out_o (source, bam_pkg::event_t): zero or more events per request, last set on the
//       final event that a request causes.
// cfg_i (sink, bam_pkg::cfg_write_t): register writes, always ready; write only while
//       the block is idle.
// A report passes from acceptance through the evaluate state, then one state each
// for the connected and the rate-limited event, before the next acceptance. The
// connected event and then the rate-limited one are loaded into the output register.
// The acceptance cycle reads the slot record and the cooldown timestamps into
// registers; the evaluation cycle works on that registered data.
// A sweep walks the pending-disconnect mask one slot per cycle until the mask is
// empty, stopping at each disconnect until the output register is free to take it.
// A clear request completes in its acceptance cycle.
// Reset: configuration returns to its defaults, all slots read absent with no baseline
// and no cooldown record, and the first snapshot counts as not yet closed.
// Receiver stall: the output register holds its event; the block accepts the next
// request once the current request's final event sits in that register, and holds
// further events until the register empties.
`default_nettype none
module battery_alert_monitor #(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 32
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  bam_stream_if.sink   in_i,
  bam_stream_if.source out_o,
  bam_stream_if.sink   cfg_i
);

  bam_pkg::ctl_cmd_t    cmd;
  bam_pkg::ctl_status_t status;
  bam_pkg::item_t       in_data;
  bam_pkg::cfg_write_t  cfg_data;
  bam_pkg::event_t      out_data;
  logic                 in_ready;
  logic                 out_valid;

  assign in_data  = in_i.data;
  assign cfg_data = cfg_i.data;

  // Sequence each request through evaluate and emit steps, or through the sweep scan.
  bam_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold slot state, configuration and the output register.
  bam_datapath #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_data_o  (out_data)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;
  // Take configuration writes in any cycle.
  assign cfg_i.ready = 1'b1;

endmodule
`default_nettype wire

@@ hw/rtl/bam_ctrl.sv @@
`default_nettype none
module bam_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire bam_pkg::ctl_status_t status_i,
  output bam_pkg::ctl_cmd_t         cmd_o
);

  bam_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bam_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      bam_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (status_i.in_report) begin
            state_d = bam_pkg::ST_EVAL;
          end else if (status_i.in_sweep) begin
            state_d = bam_pkg::ST_SCAN;
          end
        end
      end
      bam_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = bam_pkg::ST_EMIT_CONN;
      end
      bam_pkg::ST_EMIT_CONN: begin
        if (!status_i.ev_conn) begin
          state_d = bam_pkg::ST_EMIT_RL;
        end else if (!status_i.out_busy) begin
          cmd_o.load_conn = 1'b1;
          state_d         = bam_pkg::ST_EMIT_RL;
        end
      end
      bam_pkg::ST_EMIT_RL: begin
        if (!status_i.ev_rl) begin
          state_d = bam_pkg::ST_IDLE;
        end else if (!status_i.out_busy) begin
          cmd_o.load_rl = 1'b1;
          state_d       = bam_pkg::ST_IDLE;
        end
      end
      bam_pkg::ST_SCAN: begin
        if (status_i.dm_empty) begin
          state_d = bam_pkg::ST_IDLE;
        end else if (status_i.dm_bit) begin
          cmd_o.sweep_read = 1'b1;
          state_d          = bam_pkg::ST_SWEEP_EMIT;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      bam_pkg::ST_SWEEP_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.load_disc = 1'b1;
          cmd_o.scan_next = 1'b1;
          state_d         = bam_pkg::ST_SCAN;
        end
      end
      default: begin
        state_d = bam_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/bam_datapath.sv @@
`default_nettype none
module bam_datapath #(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bam_pkg::ctl_cmd_t    cmd_i,
  output bam_pkg::ctl_status_t      status_o,
  input  wire bam_pkg::item_t       in_data_i,
  input  wire logic                 cfg_valid_i,
  input  wire bam_pkg::cfg_write_t  cfg_data_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output bam_pkg::event_t           out_data_o
);

  localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CMP_W = (TIME_BITS > bam_pkg::CD_W) ? TIME_BITS : bam_pkg::CD_W;

  typedef struct packed {
    logic signed [7:0] level;
    logic [1:0]        charge;
  } rec_t;

  // Configuration registers
  logic [6:0]  low_thr_q;
  logic [6:0]  crit_thr_q;
  logic [10:0] cool_q;
  logic [4:0]  ev_en_q;

  // Latched request
  logic [SW-1:0]        slot_q;
  logic signed [7:0]    pct_q;
  logic [1:0]           chg_q;
  logic [TIME_BITS-1:0] now_q;

  // Slot memories and their registered read data
  rec_t                       rec_mem_q  [NUM_SLOTS];
  logic [2:0][TIME_BITS-1:0]  time_mem_q [NUM_SLOTS];
  rec_t                       rec_rd_q;
  logic [2:0][TIME_BITS-1:0]  time_rd_q;

  // Per-slot flags
  logic                        first_q;
  logic [NUM_SLOTS-1:0]        present_q;
  logic [NUM_SLOTS-1:0]        seen_q;
  logic [NUM_SLOTS-1:0]        recv_q;   // record written at least once
  logic [NUM_SLOTS-1:0]        basev_q;  // baseline valid
  logic [NUM_SLOTS-1:0][2:0]   nv_q;     // cooldown record valid per kind
  logic [NUM_SLOTS-1:0]        dm_q;     // pending disconnects of a sweep
  logic [SW-1:0]               idx_q;

  logic            ev_conn_q;
  logic            ev_rl_q;
  bam_pkg::event_e ev_code_q;

  logic            out_valid_q;
  bam_pkg::event_t out_q;

  logic [SW-1:0] in_idx;
  logic          slot_ok;
  logic          rd_en;
  logic [SW-1:0] rd_addr;

  assign in_idx  = SW'(in_data_i.slot);
  assign slot_ok = ({3'b000, in_data_i.slot} < 7'(NUM_SLOTS));
  assign rd_en   = cmd_i.take | cmd_i.sweep_read;
  assign rd_addr = cmd_i.take ? in_idx : idx_q;

  // Report evaluation
  logic [6:0]              low_eff, crit_eff;
  logic signed [8:0]       pct_s, low_s, crit_s, lowm_s, base_s;
  logic                    was_present, rearm, was_low, was_crit;
  logic                    pct_known, base_known, is_dis;
  logic                    full_cand, crit_cand, low_cand, rl_cand;
  logic [1:0]              prev_chg;
  logic [1:0]              kind;
  bam_pkg::event_e         code;
  logic [bam_pkg::CD_W-1:0] cd;
  logic [TIME_BITS-1:0]    diff;
  logic                    cool_ok, rl_pass;
  logic [2:0]              nv_new;
  logic [2:0][TIME_BITS-1:0] time_wr;
  logic [NUM_SLOTS-1:0]    dm_rest;
  logic                    disc_last;

  always_comb begin
    low_eff  = (low_thr_q > 7'(bam_pkg::PCT_MAX)) ? 7'(bam_pkg::PCT_MAX) : low_thr_q;
    crit_eff = (crit_thr_q > low_eff) ? low_eff : crit_thr_q;
    pct_s    = {pct_q[7], pct_q};
    low_s    = $signed({2'b00, low_eff});
    crit_s   = $signed({2'b00, crit_eff});
    lowm_s   = low_s + $signed(9'(bam_pkg::MARGIN));

    was_present = present_q[slot_q];
    prev_chg    = recv_q[slot_q] ? rec_rd_q.charge : bam_pkg::CHG_UNKNOWN;
    base_s      = basev_q[slot_q] ? {rec_rd_q.level[7], rec_rd_q.level} : -9'sd1;
    pct_known   = !pct_s[8];
    base_known  = !base_s[8];

    rearm    = (chg_q == bam_pkg::CHG_CHARGING) || (pct_known && (pct_s > lowm_s));
    was_low  = base_known && (base_s <= low_s);
    was_crit = base_known && (base_s <= crit_s);
    is_dis   = (chg_q == bam_pkg::CHG_DISCHARGING) && pct_known;

    full_cand = (chg_q == bam_pkg::CHG_FULL) && (prev_chg != bam_pkg::CHG_FULL);
    crit_cand = is_dis && (pct_s <= crit_s) && !was_crit;
    low_cand  = is_dis && !(pct_s <= crit_s) && (pct_s <= low_s) && !was_low;
    rl_cand   = full_cand | crit_cand | low_cand;

    if (full_cand) begin
      code = bam_pkg::EV_FULL;
      kind = bam_pkg::KIND_FULL;
    end else if (crit_cand) begin
      code = bam_pkg::EV_CRITICAL;
      kind = bam_pkg::KIND_CRIT;
    end else begin
      code = bam_pkg::EV_LOW;
      kind = bam_pkg::KIND_LOW;
    end

    // cooldown seconds = minutes * 64 - minutes * 4
    cd      = (bam_pkg::CD_W'(cool_q) << 6) - (bam_pkg::CD_W'(cool_q) << 2);
    diff    = now_q - time_rd_q[kind];
    cool_ok = !nv_q[slot_q][kind] || (CMP_W'(diff) >= CMP_W'(cd));
    rl_pass = first_q && rl_cand && ev_en_q[code] && cool_ok;

    nv_new = nv_q[slot_q];
    if (first_q && rearm) begin
      nv_new[2:1] = 2'b00;
    end
    if (rl_pass) begin
      nv_new[kind] = 1'b1;
    end
    time_wr       = time_rd_q;
    time_wr[kind] = now_q;

    dm_rest        = dm_q;
    dm_rest[idx_q] = 1'b0;
    disc_last      = (dm_rest == '0);
  end

  // Configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= bam_pkg::LOW_THR_RST;
      crit_thr_q <= bam_pkg::CRIT_THR_RST;
      cool_q     <= bam_pkg::COOLDOWN_RST;
      ev_en_q    <= bam_pkg::EV_EN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_data_i.index)
        bam_pkg::CFG_LOW_THR:  low_thr_q  <= cfg_data_i.value[6:0];
        bam_pkg::CFG_CRIT_THR: crit_thr_q <= cfg_data_i.value[6:0];
        bam_pkg::CFG_COOLDOWN: cool_q     <= cfg_data_i.value;
        bam_pkg::CFG_EV_EN:    ev_en_q    <= cfg_data_i.value[4:0];
        default: ;
      endcase
    end
  end

  // Slot flags and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b0;
      present_q   <= '0;
      seen_q      <= '0;
      recv_q      <= '0;
      basev_q     <= '0;
      nv_q        <= '0;
      dm_q        <= '0;
      idx_q       <= '0;
      ev_conn_q   <= 1'b0;
      ev_rl_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        case (in_data_i.op)
          bam_pkg::OP_SWEEP: begin
            dm_q      <= ev_en_q[bam_pkg::EV_DISCONNECTED] ? (present_q & ~seen_q) : '0;
            present_q <= present_q & seen_q;
            seen_q    <= '0;
            first_q   <= 1'b1;
            idx_q     <= '0;
          end
          bam_pkg::OP_CLEAR: begin
            basev_q <= '0;
            nv_q    <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_i.eval) begin
        present_q[slot_q] <= 1'b1;
        seen_q[slot_q]    <= 1'b1;
        recv_q[slot_q]    <= 1'b1;
        basev_q[slot_q]   <= 1'b1;
        nv_q[slot_q]      <= nv_new;
        ev_conn_q         <= first_q && !was_present && ev_en_q[bam_pkg::EV_CONNECTED];
        ev_rl_q           <= rl_pass;
      end
      if (cmd_i.load_disc) begin
        dm_q[idx_q] <= 1'b0;
      end
      if (cmd_i.scan_next && (idx_q != SW'(NUM_SLOTS - 1))) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.load_conn || cmd_i.load_rl || cmd_i.load_disc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers and memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      slot_q <= in_idx;
      pct_q  <= in_data_i.percent;
      chg_q  <= in_data_i.charge;
      now_q  <= TIME_BITS'(in_data_i.now_seconds);
    end
    if (rd_en) begin
      rec_rd_q  <= rec_mem_q[rd_addr];
      time_rd_q <= time_mem_q[rd_addr];
    end
    if (cmd_i.eval) begin
      rec_mem_q[slot_q] <= '{level: pct_q, charge: chg_q};
      ev_code_q         <= code;
      if (rl_pass) begin
        time_mem_q[slot_q] <= time_wr;
      end
    end
    if (cmd_i.load_conn) begin
      out_q <= '{event_res: bam_pkg::EV_CONNECTED, event_slot: 4'(slot_q),
                 event_percent: pct_q, event_charge: chg_q, last: !ev_rl_q};
    end else if (cmd_i.load_rl) begin
      out_q <= '{event_res: ev_code_q, event_slot: 4'(slot_q),
                 event_percent: pct_q, event_charge: chg_q, last: 1'b1};
    end else if (cmd_i.load_disc) begin
      out_q <= '{event_res: bam_pkg::EV_DISCONNECTED, event_slot: 4'(idx_q),
                 event_percent: rec_rd_q.level, event_charge: rec_rd_q.charge,
                 last: disc_last};
    end
  end

  assign status_o.in_report = (in_data_i.op == bam_pkg::OP_REPORT) && slot_ok;
  assign status_o.in_sweep  = (in_data_i.op == bam_pkg::OP_SWEEP);
  assign status_o.out_busy  = out_valid_q;
  assign status_o.ev_conn   = ev_conn_q;
  assign status_o.ev_rl     = ev_rl_q;
  assign status_o.dm_empty  = (dm_q == '0);
  assign status_o.dm_bit    = dm_q[idx_q];

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
